>>> rtl/strided_pattern_match_scanner_macros.svh
// ----------------------------------------------------------------------------
// strided pattern match scanner assertion macros
// shared concurrent assertion forms used by the scanner rtl
// ----------------------------------------------------------------------------
`ifndef STRIDED_PATTERN_MATCH_SCANNER_MACROS_SVH
`define STRIDED_PATTERN_MATCH_SCANNER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SPS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sps assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sps assertion failed");

`endif

>>> rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// widths, register indexes and shared types of the pattern match scanner
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int unsigned WindowBytes = 8;
  localparam int unsigned WindowW     = 8 * WindowBytes;
  localparam int unsigned DataW       = 8;
  localparam int unsigned AddrW       = 48;
  localparam int unsigned LenW        = 4;
  localparam int unsigned PhaseW      = 3;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 64;

  localparam logic [LenW-1:0] LenReset  = 4'd4;
  localparam logic [LenW-1:0] StepReset = 4'd4;
  localparam logic [LenW-1:0] StepLimit = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternBytes  = 2'd0,
    CfgPatternLength = 2'd1,
    CfgStepSize      = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] address;
  } match_t;

endpackage

`default_nettype wire

>>> rtl/sps_if.sv
// ----------------------------------------------------------------------------
// sps channel interfaces
// valid/ready channels for input bytes and match addresses
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_in_if
  import sps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             first_of_buffer;
  logic [AddrW-1:0] start_addr;

  modport source (output valid, output data_byte, output first_of_buffer,
                  output start_addr, input ready);
  modport sink   (input valid, input data_byte, input first_of_buffer,
                  input start_addr, output ready);
endinterface

interface sps_out_if
  import sps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] match_address;

  modport source (output valid, output match_address, input ready);
  modport sink   (input valid, input match_address, output ready);
endinterface

`default_nettype wire

>>> rtl/strided_pattern_match_scanner.sv
// ----------------------------------------------------------------------------
// strided_pattern_match_scanner
// aligned byte pattern search over a streamed memory buffer
// ----------------------------------------------------------------------------
// The scanner takes one buffer byte per word and accepts a word every cycle.
// A word with first_of_buffer set starts a new buffer at offset 0 and loads
// its base address. Candidate offsets are 0, step, 2*step, ... and each is
// tested on the byte that completes its pattern window, so windows that run
// past the buffer end are never tested. A match leaves as base plus offset:
// the accepted byte first updates the scan state, then the compare and
// address add load the output register. Input stalls only when the output
// register holds an unread address and the byte now under compare matches as
// well. Configuration is to be written through the plain write port while the
// scanner is idle; the block itself does not enforce this. No clearing pass is needed after reset.
`default_nettype none

`include "strided_pattern_match_scanner_macros.svh"

module strided_pattern_match_scanner
  import sps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned ADDRESS_BITS      = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sps_in_if.sink              item_i,
  sps_out_if.source           result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // pattern length limit, never above the window
  localparam int unsigned LenLimInt = (MAX_PATTERN_BYTES > WindowBytes) ? WindowBytes :
                                      ((MAX_PATTERN_BYTES < 1) ? 1 : MAX_PATTERN_BYTES);
  localparam logic [LenW-1:0] LenLimit = LenW'(LenLimInt);

  // configuration registers
  logic [WindowW-1:0] pattern_q;
  logic [LenW-1:0]    length_q;
  logic [LenW-1:0]    step_q;

  // scan state
  logic [WindowW-1:0] window_q, window_d;
  logic [AddrW-1:0]   seen_q, seen_d;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [AddrW-1:0]   base_q, base_d;

  // compare stage flags
  logic s1_valid_q, s1_valid_d;
  logic s1_cand_q, s1_cand_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] out_addr_q, out_addr_d;

  logic             accept;
  logic             s1_hit;
  logic             s1_advance;
  logic             out_free;
  logic [LenW-1:0]  len_eff;
  logic [LenW-1:0]  step_eff;
  match_t           match;

  // out-of-range lengths and steps clamp into range
  always_comb begin
    if (length_q == '0) begin
      len_eff = 4'd1;
    end else if (length_q > LenLimit) begin
      len_eff = LenLimit;
    end else begin
      len_eff = length_q;
    end
    if (step_q == '0) begin
      step_eff = 4'd1;
    end else if (step_q > StepLimit) begin
      step_eff = StepLimit;
    end else begin
      step_eff = step_q;
    end
  end

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= LenReset;
      step_q    <= StepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgPatternBytes:  pattern_q <= cfg_data_i;
        CfgPatternLength: length_q  <= cfg_data_i[LenW-1:0];
        CfgStepSize:      step_q    <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the compare stage holds only a matching word that cannot leave
  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_hit       = s1_valid_q && s1_cand_q && match.hit;
  assign s1_advance   = !s1_hit || out_free;
  assign item_i.ready = !s1_valid_q || s1_advance;
  assign accept       = item_i.valid && item_i.ready;

  // state update for the accepted byte
  always_comb begin
    logic [WindowW-1:0] win_b;
    logic [AddrW-1:0]   seen_b;
    logic [PhaseW-1:0]  phase_b;
    logic [LenW-1:0]    nxt;
    logic [AddrW-1:0]   len_x;
    logic               sat;
    logic               cand;

    win_b   = item_i.first_of_buffer ? '0 : window_q;
    seen_b  = item_i.first_of_buffer ? '0 : seen_q;
    phase_b = item_i.first_of_buffer ? '0 : phase_q;
    len_x   = {{(AddrW-LenW){1'b0}}, len_eff};
    nxt     = {1'b0, phase_b} + 4'd1;

    window_d = window_q;
    seen_d   = seen_q;
    phase_d  = phase_q;
    base_d   = base_q;
    cand     = 1'b0;
    sat      = 1'b0;

    if (accept) begin
      base_d   = item_i.first_of_buffer ? item_i.start_addr : base_q;
      // newest byte enters at the top of the window
      window_d = {item_i.data_byte, win_b[WindowW-1:DataW]};
      // the count saturates and then silences the rest of the buffer
      sat      = &seen_b;
      seen_d   = sat ? seen_b : seen_b + 1'b1;
      if (seen_d == len_x) begin
        // first full window starts the phase
        phase_d = '0;
        cand    = 1'b1;
      end else if (seen_d > len_x) begin
        phase_d = (nxt >= step_eff) ? '0 : nxt[PhaseW-1:0];
        cand    = (phase_d == '0);
      end else begin
        phase_d = phase_b;
      end
    end

    s1_cand_d  = accept ? (cand && !sat) : s1_cand_q;
    s1_valid_d = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      seen_q     <= '0;
      phase_q    <= '0;
      base_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_cand_q  <= 1'b0;
    end else begin
      window_q   <= window_d;
      seen_q     <= seen_d;
      phase_q    <= phase_d;
      base_q     <= base_d;
      s1_valid_q <= s1_valid_d;
      s1_cand_q  <= s1_cand_d;
    end
  end

  // compare stage reads the scan state, which holds while the stage is full
  sps_match_unit #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_match (
    .window_i  (window_q),
    .pattern_i (pattern_q),
    .len_i     (len_eff),
    .base_i    (base_q),
    .seen_i    (seen_q),
    .match_o   (match)
  );

  // output register, loads only matches
  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    if (s1_hit && out_free) begin
      out_valid_d = 1'b1;
      out_addr_d  = match.address;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_addr_q <= out_addr_d;
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.match_address = out_addr_q;

  // the compare stage stalls only behind a full, unread output register
  `SPS_ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, s1_valid_q && !s1_advance, out_valid_q && !result_o.ready)
  // an accepted byte always counts
  `SPS_ASSERT_NEXT(a_seen_counts, clk_i, rst_ni, accept, seen_q != '0)
  // a new result comes only from a candidate in the compare stage
  `SPS_ASSERT_IMPLIES(a_result_source, clk_i, rst_ni, $rose(out_valid_q), $past(s1_valid_q && s1_cand_q))
  // a candidate always has its whole window inside the buffer
  `SPS_ASSERT_IMPLIES(a_cand_window, clk_i, rst_ni, s1_valid_q && s1_cand_q, seen_q >= {{(AddrW-LenW){1'b0}}, len_eff})

endmodule

`default_nettype wire

>>> rtl/sps_match_unit.sv
// ----------------------------------------------------------------------------
// sps_match_unit
// window compare against the pattern and match address generation
// ----------------------------------------------------------------------------
`default_nettype none

module sps_match_unit
  import sps_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic [WindowW-1:0] window_i,
  input  logic [WindowW-1:0] pattern_i,
  input  logic [LenW-1:0]    len_i,
  input  logic [AddrW-1:0]   base_i,
  input  logic [AddrW-1:0]   seen_i,
  output match_t             match_o
);

  localparam int unsigned MaskW = (ADDRESS_BITS < AddrW) ? ADDRESS_BITS : AddrW;
  localparam logic [AddrW-1:0] AddrMask = {AddrW{1'b1}} >> (AddrW - MaskW);

  logic [WindowW-1:0]     got;
  logic [6:0]             shamt;
  logic [WindowBytes-1:0] byte_ok;
  logic [AddrW-1:0]       sum;

  // newest len bytes sit at the top of the window
  assign shamt = {4'(4'd8 - len_i), 3'b000};
  assign got   = window_i >> shamt;

  always_comb begin
    for (int i = 0; i < WindowBytes; i++) begin
      byte_ok[i] = (4'(i) >= len_i) || (got[8*i +: 8] == pattern_i[8*i +: 8]);
    end
  end

  assign sum = base_i + seen_i - {{(AddrW-LenW){1'b0}}, len_i};

  assign match_o.hit     = &byte_ok;
  assign match_o.address = sum & AddrMask;

endmodule

`default_nettype wire
